@@ src/grid_local_peak_finder_top_macros.svh @@
// Assertion macros used by the checker file of the grid local peak finder.
`ifndef GRID_LOCAL_PEAK_FINDER_TOP_MACROS_SVH
`define GRID_LOCAL_PEAK_FINDER_TOP_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define GLPF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");

// Concurrent assertion that is also checked across reset.
`define GLPF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed in %m");

`endif

@@ src/glpf_pkg.sv @@
// Shared constants and types of the grid local peak finder.
`timescale 1ns / 1ps

package glpf_pkg;

    localparam int DEF_MAX_COLS   = 32;
    localparam int DEF_VALUE_BITS = 16;
    localparam int ROW_BITS       = 5;
    localparam int COL_BITS       = 5;
    localparam int ROW_LIMIT      = 32;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 6;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [COL_BITS-1:0] cols_m1;
        logic                has_up;
        logic                has_older;
        logic                right_ok;
        logic                final_cell;
        logic                rotate;
    } cell_ctrl_t;

endpackage

@@ src/glpf_front.sv @@
// Front end: configuration registers, raster position counters and cell classification.
`timescale 1ns / 1ps

module glpf_front
    import glpf_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      cell_valid,
    output logic                      cell_stall,
    input  logic [VALUE_BITS-1:0]     cell_value,
    input  logic                      q_ready,
    output logic                      q_push,
    output cell_ctrl_t                q_ctrl,
    output logic [VALUE_BITS-1:0]     q_value
);

    localparam int ColLim = (MAX_COLS < 32) ? MAX_COLS : 32;

    logic [CFG_DATA_BITS-1:0] rows_raw_reg;
    logic [CFG_DATA_BITS-1:0] cols_raw_reg;
    logic [ROW_BITS-1:0]      row_reg;
    logic [ROW_BITS-1:0]      row_next;
    logic [COL_BITS-1:0]      col_reg;
    logic [COL_BITS-1:0]      col_next;
    logic [CFG_DATA_BITS-1:0] rows_dec;
    logic [CFG_DATA_BITS-1:0] cols_dec;
    logic [ROW_BITS-1:0]      rows_m1;
    logic [COL_BITS-1:0]      cols_m1;
    logic [COL_BITS-1:0]      col_c;
    logic                     accept;
    logic                     cfg_hit;
    logic                     row_end;
    logic                     last_row;

    assign cfg_ready  = 1'b1;
    assign cell_stall = !q_ready;
    assign accept     = cell_valid && q_ready;
    assign q_push     = accept;
    assign q_value    = cell_value;
    assign cfg_hit    = cfg_valid
                        && ((cfg_index == REG_GRID_ROWS) || (cfg_index == REG_GRID_COLS));

    assign rows_dec = rows_raw_reg - CFG_DATA_BITS'(1);
    assign cols_dec = cols_raw_reg - CFG_DATA_BITS'(1);

    always_comb
    begin
        if (rows_raw_reg == '0)
            rows_m1 = '0;
        else if (rows_raw_reg > CFG_DATA_BITS'(ROW_LIMIT))
            rows_m1 = ROW_BITS'(ROW_LIMIT - 1);
        else
            rows_m1 = rows_dec[ROW_BITS-1:0];

        if (cols_raw_reg == '0)
            cols_m1 = '0;
        else if (cols_raw_reg > CFG_DATA_BITS'(ColLim))
            cols_m1 = COL_BITS'(ColLim - 1);
        else
            cols_m1 = cols_dec[COL_BITS-1:0];
    end

    assign col_c    = (col_reg > cols_m1) ? cols_m1 : col_reg;
    assign row_end  = (col_c == cols_m1);
    assign last_row = (row_reg >= rows_m1);

    always_comb
    begin
        q_ctrl.row        = row_reg;
        q_ctrl.col        = col_c;
        q_ctrl.cols_m1    = cols_m1;
        q_ctrl.has_up     = (row_reg != '0);
        q_ctrl.has_older  = (row_reg > ROW_BITS'(1));
        q_ctrl.right_ok   = !row_end;
        q_ctrl.final_cell = row_end && last_row;
        q_ctrl.rotate     = row_end && !last_row;
    end

    always_comb
    begin
        col_next = row_end ? '0 : col_c + COL_BITS'(1);
        if (!row_end)
            row_next = row_reg;
        else if (last_row)
            row_next = '0;
        else
            row_next = row_reg + ROW_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_raw_reg <= CFG_DATA_BITS'(ROW_LIMIT);
            cols_raw_reg <= CFG_DATA_BITS'(32);
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS:
                begin
                    rows_raw_reg <= cfg_data;
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
                REG_GRID_COLS:
                begin
                    cols_raw_reg <= cfg_data;
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

@@ src/glpf_queue.sv @@
// Short first-in first-out queue between the front end and the back end.
`timescale 1ns / 1ps

module glpf_queue
    import glpf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign ready   = (count_reg != CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign dout    = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

@@ src/glpf_back.sv @@
// Back end: rotating row banks, peak decisions, last-row flush and result register.
`timescale 1ns / 1ps

module glpf_back
    import glpf_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  cell_ctrl_t            q_ctrl,
    input  logic [VALUE_BITS-1:0] q_value,
    output logic                  q_pop,
    output logic                  peak_valid,
    input  logic                  peak_stall,
    output logic [ROW_BITS-1:0]   peak_row,
    output logic [COL_BITS-1:0]   peak_col,
    output logic                  last_of_run
);

    localparam int ColLim = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int AW     = $clog2(ColLim);

    localparam logic [1:0] MODE_RUN   = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    localparam logic [1:0] BANK0 = 2'd0;
    localparam logic [1:0] BANK1 = 2'd1;
    localparam logic [1:0] BANK2 = 2'd2;

    function automatic logic [VALUE_BITS-1:0] pick(input logic [1:0] sel,
                                                  input logic [VALUE_BITS-1:0] d0,
                                                  input logic [VALUE_BITS-1:0] d1,
                                                  input logic [VALUE_BITS-1:0] d2);
        logic [VALUE_BITS-1:0] r;
        unique case (sel)
            BANK0:   r = d0;
            BANK1:   r = d1;
            default: r = d2;
        endcase
        return r;
    endfunction

    logic [1:0]                   mode_reg;
    logic [1:0]                   cur_sel_reg;
    logic [1:0]                   mid_sel_reg;
    logic [1:0]                   old_sel_reg;
    logic                         s2_valid_reg;
    cell_ctrl_t                   s2_ctrl_reg;
    logic signed [VALUE_BITS-1:0] s2_value_reg;
    logic [1:0]                   s2_mid_sel_reg;
    logic [1:0]                   s2_old_sel_reg;
    logic signed [VALUE_BITS-1:0] prev_reg;
    logic [COL_BITS-1:0]          fk_reg;
    logic                         pend_valid_reg;
    logic [ROW_BITS-1:0]          pend_row_reg;
    logic [COL_BITS-1:0]          pend_col_reg;
    logic                         out_valid_reg;
    logic [ROW_BITS-1:0]          out_row_reg;
    logic [COL_BITS-1:0]          out_col_reg;
    logic                         out_last_reg;

    logic [VALUE_BITS-1:0]        rda [3];
    logic [VALUE_BITS-1:0]        rdb [3];

    logic signed [VALUE_BITS-1:0] vm;
    logic signed [VALUE_BITS-1:0] vr;
    logic signed [VALUE_BITS-1:0] vo;
    logic signed [VALUE_BITS-1:0] vc;
    logic signed [VALUE_BITS-1:0] vcr;
    logic signed [VALUE_BITS-1:0] vu;

    logic                out_free;
    logic                run_eval;
    logic                n_peak;
    logic                s2_done;
    logic                n_push;
    logic                enter_flush;
    logic                in_flush;
    logic                f_peak;
    logic                f_done;
    logic                f_last;
    logic                f_push;
    logic                d_push;
    logic                out_push;
    logic                mem_we;
    logic                mem_re;
    logic [COL_BITS-1:0] fk_plus;
    logic [AW-1:0]       rd_addr_a;
    logic [AW-1:0]       rd_addr_b;
    logic [AW-1:0]       wr_addr;
    logic [ROW_BITS-1:0] push_row;
    logic [COL_BITS-1:0] push_col;

    assign out_free = !out_valid_reg || !peak_stall;

    assign vm  = pick(s2_mid_sel_reg, rda[0], rda[1], rda[2]);
    assign vr  = pick(s2_mid_sel_reg, rdb[0], rdb[1], rdb[2]);
    assign vo  = pick(s2_old_sel_reg, rda[0], rda[1], rda[2]);
    assign vc  = pick(cur_sel_reg, rda[0], rda[1], rda[2]);
    assign vcr = pick(cur_sel_reg, rdb[0], rdb[1], rdb[2]);
    assign vu  = pick(mid_sel_reg, rda[0], rda[1], rda[2]);

    assign run_eval = (mode_reg == MODE_RUN) && s2_valid_reg;
    assign n_peak   = s2_ctrl_reg.has_up
                      && ((s2_ctrl_reg.col == '0) || (vm >= prev_reg))
                      && (!s2_ctrl_reg.right_ok || (vm >= vr))
                      && (!s2_ctrl_reg.has_older || (vm >= vo))
                      && (vm >= s2_value_reg);
    assign s2_done     = s2_ctrl_reg.final_cell || !n_peak || out_free;
    assign n_push      = run_eval && n_peak && !s2_ctrl_reg.final_cell && out_free;
    assign enter_flush = run_eval && s2_ctrl_reg.final_cell;

    assign in_flush = (mode_reg == MODE_FLUSH);
    assign f_peak   = ((fk_reg == '0) || (vc >= prev_reg))
                      && ((fk_reg == s2_ctrl_reg.cols_m1) || (vc >= vcr))
                      && (!s2_ctrl_reg.has_up || (vc >= vu));
    assign f_done   = !(f_peak && pend_valid_reg) || out_free;
    assign f_last   = (fk_reg == s2_ctrl_reg.cols_m1);
    assign f_push   = in_flush && f_peak && pend_valid_reg && out_free;
    assign d_push   = (mode_reg == MODE_DRAIN) && pend_valid_reg && out_free;
    assign out_push = n_push || f_push || d_push;
    assign fk_plus  = fk_reg + COL_BITS'(1);

    assign q_pop = q_valid && (mode_reg == MODE_RUN)
                   && (!s2_valid_reg || (s2_done && !s2_ctrl_reg.final_cell));

    assign mem_we  = q_pop;
    assign mem_re  = q_pop || enter_flush || (in_flush && f_done && !f_last);
    assign wr_addr = q_ctrl.col[AW-1:0];

    always_comb
    begin
        if (q_pop)
            rd_addr_a = q_ctrl.col[AW-1:0];
        else if (enter_flush)
            rd_addr_a = '0;
        else
            rd_addr_a = fk_plus[AW-1:0];
        rd_addr_b = (rd_addr_a == AW'(ColLim - 1)) ? rd_addr_a : rd_addr_a + AW'(1);
    end

    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        logic [VALUE_BITS-1:0] mem [ColLim];

        always_ff @(posedge clk)
        begin
            if (mem_we && (cur_sel_reg == 2'(b)))
                mem[wr_addr] <= q_value;
            if (mem_re)
            begin
                rda[b] <= mem[rd_addr_a];
                rdb[b] <= mem[rd_addr_b];
            end
        end
    end

    always_comb
    begin
        if (n_push)
        begin
            push_row = s2_ctrl_reg.row - ROW_BITS'(1);
            push_col = s2_ctrl_reg.col;
        end
        else
        begin
            push_row = pend_row_reg;
            push_col = pend_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RUN;
            cur_sel_reg    <= BANK0;
            mid_sel_reg    <= BANK1;
            old_sel_reg    <= BANK2;
            s2_valid_reg   <= 1'b0;
            fk_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= out_push;

            if (q_pop)
            begin
                s2_valid_reg <= 1'b1;
                if (q_ctrl.rotate)
                begin
                    old_sel_reg <= mid_sel_reg;
                    mid_sel_reg <= cur_sel_reg;
                    cur_sel_reg <= old_sel_reg;
                end
            end
            else if (run_eval && s2_done)
            begin
                s2_valid_reg <= 1'b0;
            end

            unique case (mode_reg)
                MODE_RUN:
                begin
                    if (enter_flush)
                    begin
                        mode_reg       <= MODE_FLUSH;
                        fk_reg         <= '0;
                        pend_valid_reg <= n_peak;
                    end
                end
                MODE_FLUSH:
                begin
                    if (f_done)
                    begin
                        if (f_peak)
                            pend_valid_reg <= 1'b1;
                        if (f_last)
                            mode_reg <= MODE_DRAIN;
                        else
                            fk_reg <= fk_plus;
                    end
                end
                MODE_DRAIN:
                begin
                    if (!pend_valid_reg)
                        mode_reg <= MODE_RUN;
                    else if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        mode_reg       <= MODE_RUN;
                    end
                end
                default:
                begin
                    mode_reg <= MODE_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_ctrl_reg    <= q_ctrl;
            s2_value_reg   <= q_value;
            s2_mid_sel_reg <= mid_sel_reg;
            s2_old_sel_reg <= old_sel_reg;
        end

        if (run_eval && s2_done)
            prev_reg <= vm;
        else if (in_flush && f_done)
            prev_reg <= vc;

        if (enter_flush)
        begin
            pend_row_reg <= s2_ctrl_reg.row - ROW_BITS'(1);
            pend_col_reg <= s2_ctrl_reg.col;
        end
        else if (in_flush && f_done && f_peak)
        begin
            pend_row_reg <= s2_ctrl_reg.row;
            pend_col_reg <= fk_reg;
        end

        if (out_free && out_push)
        begin
            out_row_reg  <= push_row;
            out_col_reg  <= push_col;
            out_last_reg <= n_push || d_push;
        end
    end

    assign peak_valid  = out_valid_reg;
    assign peak_row    = out_row_reg;
    assign peak_col    = out_col_reg;
    assign last_of_run = out_last_reg;

endmodule

@@ src/grid_local_peak_finder_top.sv @@
// Grid local peak finder: 4-neighbour local maximum detection on a raster stream.
// The cell channel (cell_valid, cell_stall, cell_value) takes one signed grid
// value per transaction in raster order. The peak channel (peak_valid,
// peak_stall, peak_row, peak_col, last_of_run) returns the row and column of
// every cell that is not below any neighbour inside the grid, in raster order;
// last_of_run marks the final peak caused by a given cell transaction.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// grid_rows (index 0) and grid_cols (index 1); a write restarts the grid.
// Throughput is one cell per cycle while cell_stall is low: a four-entry queue
// feeds a two-stage back end whose row banks give a registered read of column c
// and c+1 per cycle. The decision for the cell above is taken from the registered
// bank reads and held in the result register. The final cell of a grid adds a
// last-row flush during which no new cell leaves the queue.
// Reset clears the counters, queue and result register, and sets both size
// registers to 32. While peak_stall is high the result register holds and the
// back end waits; cells keep entering until the queue is full, then cell_stall
// goes high.
`timescale 1ns / 1ps

module grid_local_peak_finder_top
    import glpf_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         cell_valid,
    output logic                         cell_stall,
    input  logic signed [VALUE_BITS-1:0] cell_value,
    output logic                         peak_valid,
    input  logic                         peak_stall,
    output logic [ROW_BITS-1:0]          peak_row,
    output logic [COL_BITS-1:0]          peak_col,
    output logic                         last_of_run
);

    localparam int QW = VALUE_BITS + $bits(cell_ctrl_t);

    logic                  fq_push;
    logic                  fq_ready;
    cell_ctrl_t            fq_ctrl;
    logic [VALUE_BITS-1:0] fq_value;
    logic                  qb_valid;
    logic                  qb_pop;
    logic [QW-1:0]         qb_data;
    cell_ctrl_t            qb_ctrl;
    logic [VALUE_BITS-1:0] qb_value;

    glpf_front #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_value (cell_value),
        .q_ready    (fq_ready),
        .q_push     (fq_push),
        .q_ctrl     (fq_ctrl),
        .q_value    (fq_value)
    );

    glpf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   ({fq_ctrl, fq_value}),
        .ready (fq_ready),
        .pop   (qb_pop),
        .dout  (qb_data),
        .valid (qb_valid)
    );

    assign qb_ctrl  = qb_data[QW-1:VALUE_BITS];
    assign qb_value = qb_data[VALUE_BITS-1:0];

    glpf_back #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_ctrl      (qb_ctrl),
        .q_value     (qb_value),
        .q_pop       (qb_pop),
        .peak_valid  (peak_valid),
        .peak_stall  (peak_stall),
        .peak_row    (peak_row),
        .peak_col    (peak_col),
        .last_of_run (last_of_run)
    );

endmodule

@@ src/glpf_checker.sv @@
// Port-level checker of the grid local peak finder and its bind to the top level.
`timescale 1ns / 1ps
`include "grid_local_peak_finder_top_macros.svh"

module glpf_checker
    import glpf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFG_INDEX_BITS-1:0] cfg_index,
    input logic [CFG_DATA_BITS-1:0]  cfg_data,
    input logic                      cell_valid,
    input logic                      cell_stall,
    input logic                      peak_valid,
    input logic                      peak_stall,
    input logic [ROW_BITS-1:0]       peak_row,
    input logic [COL_BITS-1:0]       peak_col,
    input logic                      last_of_run
);

    localparam int ColLim = (MAX_COLS < 32) ? MAX_COLS : 32;

    logic [CFG_DATA_BITS-1:0] rows_reg;
    logic [CFG_DATA_BITS-1:0] cols_reg;
    logic                     seen_reg;
    logic [CFG_DATA_BITS-1:0] rows_lim;
    logic [CFG_DATA_BITS-1:0] cols_lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_DATA_BITS'(ROW_LIMIT);
            cols_reg <= CFG_DATA_BITS'(32);
            seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && (cfg_index == REG_GRID_ROWS))
                rows_reg <= cfg_data;
            if (cfg_valid && cfg_ready && (cfg_index == REG_GRID_COLS))
                cols_reg <= cfg_data;
            if (cell_valid && !cell_stall)
                seen_reg <= 1'b1;
        end
    end

    always_comb
    begin
        if (rows_reg == '0)
            rows_lim = CFG_DATA_BITS'(1);
        else if (rows_reg > CFG_DATA_BITS'(ROW_LIMIT))
            rows_lim = CFG_DATA_BITS'(ROW_LIMIT);
        else
            rows_lim = rows_reg;

        if (cols_reg == '0)
            cols_lim = CFG_DATA_BITS'(1);
        else if (cols_reg > CFG_DATA_BITS'(ColLim))
            cols_lim = CFG_DATA_BITS'(ColLim);
        else
            cols_lim = cols_reg;
    end

    `GLPF_ASSERT(a_peak_hold, clk, rst_n, peak_valid && peak_stall |=> peak_valid && $stable(peak_row) && $stable(peak_col) && $stable(last_of_run))
    `GLPF_ASSERT(a_peak_in_grid, clk, rst_n, peak_valid |-> (CFG_DATA_BITS'(peak_row) < rows_lim) && (CFG_DATA_BITS'(peak_col) < cols_lim))
    `GLPF_ASSERT(a_peak_after_cell, clk, rst_n, peak_valid |-> seen_reg)
    `GLPF_ASSERT_ALWAYS(a_quiet_after_reset, clk, $rose(rst_n) |-> !peak_valid)

endmodule

bind grid_local_peak_finder_top glpf_checker #(
    .MAX_COLS (MAX_COLS)
) u_glpf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_valid  (cell_valid),
    .cell_stall  (cell_stall),
    .peak_valid  (peak_valid),
    .peak_stall  (peak_stall),
    .peak_row    (peak_row),
    .peak_col    (peak_col),
    .last_of_run (last_of_run)
);

@@ tb/tb_grid_local_peak_finder_top.sv @@
// Self-checking testbench for the grid local peak finder with a peak scoreboard.
`timescale 1ns / 1ps

module tb_grid_local_peak_finder_top
    import glpf_pkg::*;
();

    localparam int VB = DEF_VALUE_BITS;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 50;

    typedef logic signed [VB-1:0] cell_t;
    typedef cell_t row_vals_t [DEF_MAX_COLS];

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } peak_t;

    class peak_scoreboard;
        logic [CFG_DATA_BITS-1:0] rows_reg;
        logic [CFG_DATA_BITS-1:0] cols_reg;
        row_vals_t older_row;
        row_vals_t middle_row;
        row_vals_t current_row;
        int unsigned row_pos;
        int unsigned col_pos;
        peak_t pending_peaks[$];
        int unsigned cells_noted;
        int unsigned peaks_checked;
        int unsigned errors;

        function new();
            rows_reg = CFG_DATA_BITS'(ROW_LIMIT);
            cols_reg = CFG_DATA_BITS'(DEF_MAX_COLS);
            row_pos = 0;
            col_pos = 0;
            cells_noted = 0;
            peaks_checked = 0;
            errors = 0;
            foreach (older_row[i])
            begin
                older_row[i] = '0;
                middle_row[i] = '0;
                current_row[i] = '0;
            end
        endfunction

        function int unsigned clamp_size(logic [CFG_DATA_BITS-1:0] v, int unsigned limit);
            if (v == 0)
                return 1;
            if (v > limit)
                return limit;
            return v;
        endfunction

        function void configure(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
            if (index == REG_GRID_ROWS)
                rows_reg = data;
            else if (index == REG_GRID_COLS)
                cols_reg = data;
            else
                return;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function bit cell_is_peak(row_vals_t mid, bit has_up, row_vals_t up,
                                  bit has_down, row_vals_t down,
                                  int unsigned c, int unsigned cols);
            cell_t v;
            v = mid[c];
            if (c > 0 && v < mid[c - 1])
                return 1'b0;
            if (c + 1 < cols && v < mid[c + 1])
                return 1'b0;
            if (has_up && v < up[c])
                return 1'b0;
            if (has_down && v < down[c])
                return 1'b0;
            return 1'b1;
        endfunction

        function void note_cell(cell_t value);
            int unsigned rows;
            int unsigned cols;
            int unsigned r;
            int unsigned c;
            peak_t found[$];
            rows = clamp_size(rows_reg, ROW_LIMIT);
            cols = clamp_size(cols_reg, DEF_MAX_COLS);
            r = row_pos;
            c = col_pos;
            if (c >= cols)
                c = cols - 1;
            current_row[c] = value;
            cells_noted++;
            if (r >= 1 && cell_is_peak(middle_row, r >= 2, older_row, 1'b1, current_row,
                                       c, cols))
                found.push_back('{row: ROW_BITS'(r - 1), col: COL_BITS'(c), last: 1'b0});
            if (c + 1 >= cols)
            begin
                if (r + 1 >= rows)
                begin
                    for (int unsigned k = 0; k < cols; k++)
                    begin
                        if (cell_is_peak(current_row, r >= 1, middle_row, 1'b0, current_row,
                                         k, cols))
                            found.push_back('{row: ROW_BITS'(r), col: COL_BITS'(k),
                                              last: 1'b0});
                    end
                    row_pos = 0;
                end
                else
                begin
                    older_row = middle_row;
                    middle_row = current_row;
                    row_pos = (r + 1) % 32;
                end
                col_pos = 0;
            end
            else
            begin
                col_pos = c + 1;
            end
            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                pending_peaks.push_back(found[i]);
        endfunction

        function void check_peak(logic [ROW_BITS-1:0] row, logic [COL_BITS-1:0] col,
                                 logic last);
            peak_t want;
            peaks_checked++;
            if (pending_peaks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected peak transaction: expected none, got row %0d col %0d last %0d",
                         $time, row, col, last);
                return;
            end
            want = pending_peaks.pop_front();
            if (row !== want.row)
            begin
                errors++;
                $display("%0t: peak_row mismatch: expected %0d, got %0d", $time, want.row, row);
            end
            if (col !== want.col)
            begin
                errors++;
                $display("%0t: peak_col mismatch: expected %0d, got %0d", $time, want.col, col);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last_of_run mismatch: expected %0d, got %0d", $time,
                         want.last, last);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      cell_valid;
    logic                      cell_stall;
    cell_t                     cell_value;
    logic                      peak_valid;
    logic                      peak_stall;
    logic [ROW_BITS-1:0]       peak_row;
    logic [COL_BITS-1:0]       peak_col;
    logic                      last_of_run;

    peak_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned grid_settings = 0;

    grid_local_peak_finder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_value (cell_value),
        .peak_valid (peak_valid),
        .peak_stall (peak_stall),
        .peak_row   (peak_row),
        .peak_col   (peak_col),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        peak_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                peak_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                peak_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && peak_valid && !peak_stall)
            sb.check_peak(peak_row, peak_col, last_of_run);
    end

    function automatic cell_t pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return cell_t'(int'($urandom_range(0, 4)) - 2);
        if (sel < 8)
            return cell_t'($urandom());
        if (sel == 8)
            return cell_t'(16'h8000);
        return cell_t'(16'h7fff);
    endfunction

    task automatic send_cell(input cell_t value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_value <= value;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        sb.note_cell(value);
    endtask

    task automatic settle();
        @(posedge clk);
        while (sb.pending_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [CFG_DATA_BITS-1:0] rows_d,
                               input logic [CFG_DATA_BITS-1:0] cols_d);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_data <= rows_d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.configure(REG_GRID_ROWS, rows_d);
        cfg_index <= REG_GRID_COLS;
        cfg_data <= cols_d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.configure(REG_GRID_COLS, cols_d);
        cfg_valid <= 1'b0;
        grid_settings++;
    endtask

    task automatic play_grid(input logic [CFG_DATA_BITS-1:0] rows_d,
                             input logic [CFG_DATA_BITS-1:0] cols_d,
                             input cell_t vals[$], input bit with_hold);
        settle();
        write_sizes(rows_d, cols_d);
        if (with_hold)
            hold_req = 1'b1;
        foreach (vals[i])
            send_cell(vals[i]);
        cell_valid <= 1'b0;
    endtask

    initial
    begin
        cell_t vals[$];
        int unsigned random_cells;
        int unsigned n;
        int phase;
        int phase_now;
        logic [CFG_DATA_BITS-1:0] rows_d;
        logic [CFG_DATA_BITS-1:0] cols_d;
        bit with_hold;

        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GRID_ROWS;
        cfg_data <= '0;
        cell_valid <= 1'b0;
        cell_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_stall_pct = 70;
        send_cell(cell_t'(16'h7fff));
        send_cell(cell_t'(16'h8000));
        send_cell(cell_t'(0));
        cell_valid <= 1'b0;

        vals = {cell_t'(16'h8000), cell_t'(16'h7fff)};
        play_grid(6'd0, 6'd0, vals, 1'b0);
        vals = {cell_t'(5), cell_t'(5), cell_t'(16'h8000),
                cell_t'(5), cell_t'(16'h7fff), cell_t'(4)};
        play_grid(6'd2, 6'd3, vals, 1'b0);
        vals = {cell_t'(1), cell_t'(1), cell_t'(0), cell_t'(2)};
        play_grid(6'd4, 6'd1, vals, 1'b0);
        vals = {cell_t'(-1), cell_t'(-1), cell_t'(-2), cell_t'(-1)};
        play_grid(6'd1, 6'd4, vals, 1'b0);

        random_cells = 0;
        phase = -1;
        while (random_cells < 200)
        begin
            phase_now = (random_cells < 67) ? 0 : (random_cells < 134) ? 1 : 2;
            vals.delete();
            with_hold = 1'b0;
            if (phase_now != phase)
            begin
                phase = phase_now;
                case (phase)
                    0:
                    begin
                        send_idle_pct = 13;
                        recv_stall_pct = 70;
                        rows_d = 6'd32;
                        cols_d = 6'd1;
                    end
                    1:
                    begin
                        send_idle_pct = 70;
                        recv_stall_pct = 13;
                        rows_d = 6'd1;
                        cols_d = CFG_DATA_BITS'($urandom_range(33, 63));
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_stall_pct = 0;
                        rows_d = CFG_DATA_BITS'($urandom_range(33, 63));
                        cols_d = 6'd1;
                        with_hold = 1'b1;
                    end
                endcase
            end
            else
            begin
                rows_d = ($urandom_range(0, 9) == 0) ? 6'd0 :
                         CFG_DATA_BITS'($urandom_range(1, 6));
                cols_d = ($urandom_range(0, 9) == 0) ? 6'd0 :
                         CFG_DATA_BITS'($urandom_range(1, 8));
            end
            n = sb.clamp_size(rows_d, ROW_LIMIT) * sb.clamp_size(cols_d, DEF_MAX_COLS);
            // Now and then the grid is cut short so that the next write restarts it.
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, n);
            repeat (n) vals.push_back(pick_value());
            play_grid(rows_d, cols_d, vals, with_hold);
            random_cells += n;
        end

        settle();
        $display("Checked %0d cell transactions and %0d peak transactions over %0d grid sizes,",
                 sb.cells_noted, sb.peaks_checked, grid_settings);
        $display("from 1x1 up to 32-cell rows and columns, with clamped sizes and a long hold-off.");
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/glpf_pkg.sv
src/glpf_front.sv
src/glpf_queue.sv
src/glpf_back.sv
src/grid_local_peak_finder_top.sv
src/glpf_checker.sv
tb/tb_grid_local_peak_finder_top.sv
